// ===== rtl/hic_pkg.sv =====
package hic_pkg;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_INST,
      S_DEC,
      S_RDB,
      S_IMM,
      S_ALU,
      S_DIV,
      S_CMP,
      S_LABEL,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_E3_CHK,
      S_E3_PREV,
      S_E3_CUR,
      S_E5,
      S_STORE,
      S_E7,
      S_LOAD,
      S_PRINT_MEM,
      S_RESP
   } st_type;

   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_AND,
      ALU_OR,
      ALU_SHL,
      ALU_SAR
   } alu_op_type;

   localparam logic [1:0] OP_MEMW = 2'd0;
   localparam logic [1:0] OP_REGW = 2'd1;
   localparam logic [1:0] OP_EXEC = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BADOP = 2'd1;
   localparam logic [1:0] ST_NOLAB = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam logic [1:0] FLAG_EQ = 2'd0;
   localparam logic [1:0] FLAG_GT = 2'd1;
   localparam logic [1:0] FLAG_LT = 2'd3;

   localparam logic [3:0] GRP_LAST_LABEL = 4'h9;
   localparam logic [3:0] GRP_ARITH      = 4'hA;
   localparam logic [3:0] GRP_LOGIC      = 4'hB;
   localparam logic [3:0] GRP_BAD        = 4'hC;
   localparam logic [3:0] GRP_JUMP       = 4'hD;
   localparam logic [3:0] GRP_MOVE       = 4'hE;
   localparam logic [3:0] GRP_PRINT      = 4'hF;

   localparam logic [3:0] SUB_JMP  = 4'h0;
   localparam logic [3:0] SUB_CMP  = 4'h1;
   localparam logic [3:0] SUB_JE   = 4'h2;
   localparam logic [3:0] SUB_JL   = 4'h3;
   localparam logic [3:0] SUB_JG   = 4'h4;
   localparam logic [3:0] SUB_JLE  = 4'h5;
   localparam logic [3:0] SUB_JGE  = 4'h6;

   localparam logic [3:0] SUB_LDPC = 4'h0;
   localparam logic [3:0] SUB_MOV  = 4'h1;
   localparam logic [3:0] SUB_INP  = 4'h2;
   localparam logic [3:0] SUB_STR  = 4'h3;
   localparam logic [3:0] SUB_LD   = 4'h4;
   localparam logic [3:0] SUB_CPY  = 4'h5;
   localparam logic [3:0] SUB_STPC = 4'h6;
   localparam logic [3:0] SUB_LDI  = 4'h7;

   localparam logic [3:0] SUB_PREG = 4'h0;
   localparam logic [3:0] SUB_PMEM = 4'h5;

   localparam logic [3:0] REG_PC = 4'hF;

   localparam logic [31:0] CH_BSLASH = 32'h0000_005C;
   localparam logic [31:0] CH_ZERO   = 32'h0000_0030;

endpackage

// ===== rtl/hic_mem.sv =====
module hic_mem #(
   parameter int MEM_WORDS = 4096,
   localparam int AW = $clog2(MEM_WORDS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data,
   output logic          ready
);

   logic [31:0]   mem [0:MEM_WORDS-1];
   logic [AW-1:0] clr_ff;
   logic          clearing_ff;
   logic [31:0]   rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == AW'(MEM_WORDS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign ready   = ~clearing_ff;

endmodule

// ===== rtl/hic_alu.sv =====
module hic_alu (
   input  hic_pkg::alu_op_type op,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   output logic [31:0]         y
);
   import hic_pkg::*;

   always_comb begin
      case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         ALU_MUL: y = a * b;
         ALU_AND: y = a & b;
         ALU_OR:  y = a | b;
         ALU_SHL: y = a << b[4:0];
         ALU_SAR: y = $unsigned($signed(a) >>> b[4:0]);
         default: y = '0;
      endcase
   end

endmodule

// ===== rtl/hic_rem.sv =====
module hic_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] result
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] num_ff;
   logic [31:0] den_ff;
   logic [31:0] rem_ff;
   logic        neg_ff;
   logic        zero_ff;
   logic [32:0] trial;

   assign trial = {rem_ff, num_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == 5'd31);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= '0;
         rem_ff  <= '0;
         num_ff  <= dividend[31] ? 32'd0 - dividend : dividend;
         den_ff  <= divisor[31] ? 32'd0 - divisor : divisor;
         neg_ff  <= dividend[31];
         zero_ff <= (divisor == '0);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         num_ff <= {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= 32'(trial - {1'b0, den_ff});
         end else begin
            rem_ff <= trial[31:0];
         end
      end
   end

   assign done   = done_ff;
   assign result = zero_ff ? 32'd0 : (neg_ff ? 32'd0 - rem_ff : rem_ff);

endmodule

// ===== rtl/hex_instruction_cpu_step_core.sv =====
// Steps a 16-bit-instruction machine with sixteen 32-bit registers (r15 is
// the program counter) over a MEM_WORDS-word memory. Each request word writes
// a memory word, writes a register or executes one instruction (the unused
// operation code does none of these), and gives exactly one response word.
// Execution is paced by the single registered memory read port and the
// sequencer that issues one fetch, register read or memory read per step; a
// halted machine fetches nothing. A remainder runs in the bit-serial remainder
// unit. A taken jump scans memory for its label, reading and then comparing
// one word at a time through at most all MEM_WORDS words, and a string skip
// reads the previous and the current word for each word. After reset a
// clearing pass zeroes memory before the first request word is accepted.
module hex_instruction_cpu_step_core #(
   parameter int MEM_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_address,
   input  logic [3:0]  req_reg_index,
   input  logic [31:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_print_valid,
   output logic [31:0] rsp_print_value,
   output logic        rsp_halted,
   output logic [1:0]  rsp_status,
   output logic [12:0] rsp_program_counter
);
   import hic_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [31:0] MEM_LIM = 32'(MEM_WORDS);

   st_type      state_ff, state_in;
   logic [31:0] rf_ff [0:15];
   logic [31:0] pc_ff, pc_in;
   logic [1:0]  flag_ff, flag_in;
   logic        halt_ff, halt_in;
   logic [31:0] inst_ff, inst_in;
   logic [31:0] opa_ff, opa_in;
   logic [31:0] opb_ff, opb_in;
   logic [3:0]  dst_ff, dst_in;
   logic [31:0] lab_ff, lab_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic        pv_ff, pv_in;
   logic [31:0] pval_ff, pval_in;
   logic [1:0]  st_ff, st_in;

   logic          rf_we;
   logic [3:0]    rf_wi;
   logic [31:0]   rf_wd;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [31:0]   mem_wd;
   logic [AW-1:0] mem_ra;
   logic [31:0]   mem_rd;
   logic          mem_ready;

   logic [3:0]  grp, fb, fc, fd;
   logic [3:0]  rsel;
   logic [31:0] rval;
   logic        dec_use_c;
   logic        pc_ok, rv_ok, rd_ok, opa_ok;
   logic        take;
   logic        scan_hit, scan_last;
   logic [31:0] scan_ext;
   logic [31:0] req_addr_ext;
   logic [31:0] pc_m1;
   alu_op_type  aop;
   logic        is_rem;
   logic [31:0] alu_y;
   logic        rem_start, rem_done;
   logic [31:0] rem_y;
   logic [31:0] pc_sat;

   hic_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd),
      .ready   (mem_ready)
   );

   hic_alu u_alu (
      .op (aop),
      .a  (opa_ff),
      .b  (opb_ff),
      .y  (alu_y)
   );

   hic_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (opa_ff),
      .divisor  (opb_ff),
      .done     (rem_done),
      .result   (rem_y)
   );

   // decode and shared conditions
   always_comb begin
      grp = (inst_ff[31:16] != '0) ? GRP_BAD : inst_ff[15:12];
      fb  = inst_ff[11:8];
      fc  = inst_ff[7:4];
      fd  = inst_ff[3:0];
      dec_use_c = (((grp == GRP_ARITH) || (grp == GRP_LOGIC)) && (fb < 4'd4)) ||
                  ((grp == GRP_JUMP) && (fb == SUB_CMP)) ||
                  ((grp == GRP_MOVE) && (fb == SUB_CPY));
      rsel = ((state_ff == S_DEC) && dec_use_c) ? fc : fd;
      rval = (rsel == REG_PC) ? pc_ff : rf_ff[rsel];
      pc_ok  = pc_ff < MEM_LIM;
      rv_ok  = rval < MEM_LIM;
      rd_ok  = mem_rd < MEM_LIM;
      opa_ok = opa_ff < MEM_LIM;
      pc_m1  = pc_ff - 32'd1;
      req_addr_ext = 32'(req_address);
      scan_ext = 32'(scan_ff);
      scan_hit  = (mem_rd == lab_ff) && (scan_ext != pc_ff);
      scan_last = scan_ff == AW'(MEM_WORDS - 1);
      case (fb)
         SUB_JMP: take = 1'b1;
         SUB_JE:  take = flag_ff == FLAG_EQ;
         SUB_JL:  take = flag_ff == FLAG_LT;
         SUB_JG:  take = flag_ff == FLAG_GT;
         SUB_JLE: take = (flag_ff == FLAG_EQ) || (flag_ff == FLAG_LT);
         default: take = (flag_ff == FLAG_EQ) || (flag_ff == FLAG_GT);
      endcase
      is_rem = (grp == GRP_ARITH) && (fb[1:0] == 2'd3);
      case ({grp == GRP_LOGIC, fb[1:0]})
         3'b000:  aop = ALU_ADD;
         3'b001:  aop = ALU_SUB;
         3'b010:  aop = ALU_MUL;
         3'b100:  aop = ALU_AND;
         3'b101:  aop = ALU_OR;
         3'b110:  aop = ALU_SHL;
         3'b111:  aop = ALU_SAR;
         default: aop = ALU_ADD;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (mem_ready) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_operation == OP_EXEC) ? S_FETCH : S_RESP;
            end
         end
         S_FETCH: state_in = (halt_ff || !pc_ok) ? S_RESP : S_INST;
         S_INST:  state_in = S_DEC;
         S_DEC: begin
            state_in = S_RESP;
            case (grp)
               GRP_ARITH, GRP_LOGIC: begin
                  if (fb < 4'd4) state_in = S_RDB;
                  else if (fb < 4'd8 && pc_ok) state_in = S_IMM;
               end
               GRP_JUMP: begin
                  if (fb == SUB_CMP) state_in = S_RDB;
                  else if (fb < 4'd7 && take && pc_ok) state_in = S_LABEL;
               end
               GRP_MOVE: begin
                  case (fb)
                     SUB_LDPC: if (pc_ok) state_in = S_LOAD;
                     SUB_STR:  state_in = S_E3_CHK;
                     SUB_LD:   if (rv_ok) state_in = S_LOAD;
                     SUB_CPY:  state_in = S_E5;
                     SUB_STPC: if (rv_ok) state_in = S_STORE;
                     SUB_LDI:  if (pc_ok) state_in = S_E7;
                     default:  state_in = S_RESP;
                  endcase
               end
               GRP_PRINT: if (fb == SUB_PMEM && rv_ok) state_in = S_PRINT_MEM;
               default: state_in = S_RESP;
            endcase
         end
         S_RDB:  state_in = (grp == GRP_JUMP) ? S_CMP : S_ALU;
         S_IMM:  state_in = S_ALU;
         S_ALU:  state_in = is_rem ? S_DIV : S_RESP;
         S_DIV:  if (rem_done) state_in = S_RESP;
         S_CMP:  state_in = S_RESP;
         S_LABEL: state_in = S_SCAN_RD;
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: state_in = (scan_hit || scan_last) ? S_RESP : S_SCAN_RD;
         S_E3_CHK: state_in = (!pc_ok || pc_ff == '0) ? S_RESP : S_E3_PREV;
         S_E3_PREV: state_in = (mem_rd == CH_BSLASH) ? S_RESP : S_E3_CUR;
         S_E3_CUR: state_in = (mem_rd == CH_ZERO) ? S_RESP : S_E3_CHK;
         S_E5:   state_in = rv_ok ? S_STORE : S_RESP;
         S_STORE: state_in = S_RESP;
         S_E7:   state_in = rd_ok ? S_LOAD : S_RESP;
         S_LOAD: state_in = S_RESP;
         S_PRINT_MEM: state_in = S_RESP;
         S_RESP: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      pc_in   = pc_ff;
      flag_in = flag_ff;
      halt_in = halt_ff;
      inst_in = inst_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      dst_in  = dst_ff;
      lab_in  = lab_ff;
      scan_in = scan_ff;
      pv_in   = pv_ff;
      pval_in = pval_ff;
      st_in   = st_ff;
      rf_we   = 1'b0;
      rf_wi   = fd;
      rf_wd   = rval;
      mem_we  = 1'b0;
      mem_wa  = req_addr_ext[AW-1:0];
      mem_wd  = req_data;
      mem_ra  = pc_ff[AW-1:0];
      rem_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pv_in   = 1'b0;
               pval_in = '0;
               st_in   = ST_OK;
               if (req_operation == OP_MEMW) begin
                  mem_we = req_addr_ext < MEM_LIM;
               end else if (req_operation == OP_REGW) begin
                  rf_we = 1'b1;
                  rf_wi = req_reg_index;
                  rf_wd = req_data;
               end
            end
         end
         S_FETCH: if (!halt_ff && pc_ok) pc_in = pc_ff + 32'd1;
         S_INST:  inst_in = mem_rd;
         S_DEC: begin
            opa_in = rval;
            case (grp)
               GRP_ARITH, GRP_LOGIC: begin
                  if (fb < 4'd4) begin
                     dst_in = fc;
                  end else if (fb < 4'd8) begin
                     dst_in = fd;
                     pc_in  = pc_ff + 32'd1;
                     if (!pc_ok) st_in = ST_RANGE;
                  end else begin
                     st_in   = ST_BADOP;
                     halt_in = 1'b1;
                  end
               end
               GRP_JUMP: begin
                  if (fb >= 4'd7) begin
                     st_in   = ST_BADOP;
                     halt_in = 1'b1;
                  end else if (fb != SUB_CMP) begin
                     if (!take) pc_in = pc_ff + 32'd1;
                     else if (!pc_ok) st_in = ST_RANGE;
                  end
               end
               GRP_MOVE: begin
                  dst_in = fd;
                  case (fb)
                     SUB_LDPC: if (!pc_ok) st_in = ST_RANGE;
                     SUB_MOV: begin
                        rf_we = 1'b1;
                        rf_wi = fc;
                     end
                     SUB_INP: ;
                     SUB_STR: begin
                        rf_we = 1'b1;
                        rf_wd = pc_ff;
                     end
                     SUB_LD: begin
                        dst_in = fc;
                        mem_ra = rval[AW-1:0];
                        if (!rv_ok) st_in = ST_RANGE;
                     end
                     SUB_CPY: ;
                     SUB_STPC: begin
                        opa_in = pc_ff;
                        mem_ra = rval[AW-1:0];
                        if (!rv_ok) st_in = ST_RANGE;
                     end
                     SUB_LDI: if (!pc_ok) st_in = ST_RANGE;
                     default: begin
                        st_in   = ST_BADOP;
                        halt_in = 1'b1;
                     end
                  endcase
               end
               GRP_PRINT: begin
                  if (fb == SUB_PREG) begin
                     pv_in   = 1'b1;
                     pval_in = rval;
                  end else if (fb == SUB_PMEM) begin
                     mem_ra = rval[AW-1:0];
                     if (!rv_ok) st_in = ST_RANGE;
                  end else if (fb >= 4'd6) begin
                     st_in   = ST_BADOP;
                     halt_in = 1'b1;
                  end
               end
               GRP_BAD: begin
                  st_in   = ST_BADOP;
                  halt_in = 1'b1;
               end
               default: ;
            endcase
         end
         S_RDB: opb_in = rval;
         S_IMM: begin
            opb_in = mem_rd;
            // r15 as target sees the pc past the immediate
            if (dst_ff == REG_PC) opa_in = pc_ff;
         end
         S_ALU: begin
            if (is_rem) begin
               rem_start = 1'b1;
            end else begin
               rf_we = 1'b1;
               rf_wi = dst_ff;
               rf_wd = alu_y;
            end
         end
         S_DIV: begin
            rf_we = rem_done;
            rf_wi = dst_ff;
            rf_wd = rem_y;
         end
         S_CMP: begin
            if (opa_ff == opb_ff) flag_in = FLAG_EQ;
            else if ($signed(opa_ff) < $signed(opb_ff)) flag_in = FLAG_LT;
            else flag_in = FLAG_GT;
         end
         S_LABEL: begin
            lab_in  = mem_rd;
            scan_in = '0;
         end
         S_SCAN_RD: mem_ra = scan_ff;
         S_SCAN_CMP: begin
            if (scan_hit) pc_in = scan_ext + 32'd1;
            else if (scan_last) st_in = ST_NOLAB;
            else scan_in = scan_ff + 1'b1;
         end
         S_E3_CHK: begin
            mem_ra = pc_m1[AW-1:0];
            if (!pc_ok || pc_ff == '0) st_in = ST_RANGE;
         end
         S_E3_PREV: mem_ra = pc_ff[AW-1:0];
         S_E3_CUR: if (mem_rd != CH_ZERO) pc_in = pc_ff + 32'd1;
         S_E5: begin
            mem_ra = rval[AW-1:0];
            if (!rv_ok) st_in = ST_RANGE;
         end
         S_STORE: begin
            mem_wa = opa_ff[AW-1:0];
            mem_wd = mem_rd;
            mem_we = opa_ok;
            if (!opa_ok) st_in = ST_RANGE;
         end
         S_E7: begin
            mem_ra = mem_rd[AW-1:0];
            if (!rd_ok) st_in = ST_RANGE;
         end
         S_LOAD: begin
            rf_we = 1'b1;
            rf_wi = dst_ff;
            rf_wd = mem_rd;
         end
         S_PRINT_MEM: begin
            pv_in   = 1'b1;
            pval_in = mem_rd;
         end
         default: ;
      endcase
      if (rf_we && rf_wi == REG_PC) pc_in = rf_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pc_ff    <= '0;
         flag_ff  <= FLAG_EQ;
         halt_ff  <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            rf_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         flag_ff  <= flag_in;
         halt_ff  <= halt_in;
         if (rf_we && rf_wi != REG_PC) begin
            rf_ff[rf_wi] <= rf_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      inst_ff <= inst_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      dst_ff  <= dst_in;
      lab_ff  <= lab_in;
      scan_ff <= scan_in;
      pv_ff   <= pv_in;
      pval_ff <= pval_in;
      st_ff   <= st_in;
   end

   assign pc_sat = pc_ok ? pc_ff : MEM_LIM;

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = (state_ff == S_RESP);
   assign rsp_print_valid     = pv_ff;
   assign rsp_print_value     = pval_ff;
   assign rsp_halted          = halt_ff || !pc_ok;
   assign rsp_status          = st_ff;
   assign rsp_program_counter = pc_sat[12:0];

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("error halt cleared without reset");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      !mem_ready |-> req_stall)
      else $error("request taken during memory clear");

   a_rem_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && rem_done |=> state_ff == S_RESP)
      else $error("remainder result not written back");

   a_badop_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BADOP) |-> rsp_halted)
      else $error("invalid opcode without halt");

endmodule
